>>> hw/rtl/power_feedforward_fan_boost_unit_macros.svh
// -----------------------------------------------------------------------------
// Assertion macros for the power feed-forward fan boost unit
// Immediate-antecedent and next-cycle property forms, clocked on clk and
// disabled while arst_n is low.
// -----------------------------------------------------------------------------
`ifndef POWER_FEEDFORWARD_FAN_BOOST_UNIT_MACROS_SVH
`define POWER_FEEDFORWARD_FAN_BOOST_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PFB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PFB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/pfb_pkg.sv
// -----------------------------------------------------------------------------
// Power feed-forward fan boost package
// Widths, reset values, register indexes, constants and the types shared by
// the controller and the datapath.
// -----------------------------------------------------------------------------
package pfb_pkg;

	localparam int TIME_W      = 32;
	localparam int POWER_W     = 16;
	localparam int TEMP_W      = 12;
	localparam int PCT_W       = 7;
	localparam int THR_W       = 16;
	localparam int MS_W        = 20;
	localparam int BAND_W      = 10;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 20;
	localparam int IN_TDATA_W  = 64;
	localparam int OUT_TDATA_W = 16;

	localparam int POWER_LSB = TIME_W;
	localparam int TEMP_LSB  = TIME_W + POWER_W;
	localparam int OUT_PAD_W = OUT_TDATA_W - 2 * PCT_W;

	localparam logic [THR_W-1:0]  THR_RST     = 16'd500;
	localparam logic [MS_W-1:0]   FADE_RST    = 20'd30000;
	localparam logic [MS_W-1:0]   LEARN_RST   = 20'd60000;
	localparam logic [BAND_W-1:0] BAND_RST    = 10'd5;
	localparam logic [PCT_W-1:0]  PCT_MIN_RST = 7'd10;
	localparam logic [PCT_W-1:0]  PCT_MAX_RST = 7'd100;
	localparam logic [PCT_W-1:0]  START_PCT   = 7'd30;

	localparam logic [TIME_W-1:0] ACTIVATE_MS = 32'd5000;
	localparam int ALPHA_Q8 = 77;

	// Rate is |dT|*60000/L; the step ALPHA/256*|rate|*2/10 reduces to
	// |dT|*ALPHA*375 / (8*L).
	localparam int RATE_K     = 60000;
	localparam int STEP_K     = ALPHA_Q8 * 375;
	localparam int STEP_SHIFT = 3;

	localparam int MAG_W       = TEMP_W;
	localparam int RATE_PROD_W = 28;
	localparam int BAND_PROD_W = BAND_W + MS_W;
	localparam int FADE_PROD_W = PCT_W + MS_W;
	localparam int DIV_NUM_W   = 29;
	localparam int DIV_DEN_W   = MS_W + STEP_SHIFT;
	localparam int DIV_CNT_W   = $clog2(DIV_NUM_W);
	localparam int QW          = DIV_NUM_W + 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_THRESHOLD_POWER = 3'd0,
		CFG_FADE_MS         = 3'd1,
		CFG_LEARN_MS        = 3'd2,
		CFG_RATE_DEADBAND   = 3'd3,
		CFG_PCT_MIN         = 3'd4,
		CFG_PCT_MAX         = 3'd5,
		CFG_START_PCT       = 3'd6,
		CFG_LEARNING_LOCKED = 3'd7
	} cfg_idx_t;

	typedef enum logic [1:0] {
		KIND_ZERO  = 2'd0,
		KIND_BOOST = 2'd1,
		KIND_LEARN = 2'd2,
		KIND_FADE  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'd0,
		ST_DECIDE = 3'd1,
		ST_MULT   = 3'd2,
		ST_START  = 3'd3,
		ST_DIV    = 3'd4,
		ST_COMMIT = 3'd5
	} state_t;

	typedef struct packed {
		logic capture;
		logic decide;
		logic mult;
		logic div_start;
		logic commit;
	} pfb_cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  div_busy;
		logic  out_free;
	} pfb_status_t;

endpackage

>>> hw/rtl/pfb_div.sv
// -----------------------------------------------------------------------------
// Shared restoring divider
// Unsigned division, one quotient bit per cycle, with a flag for a non-zero
// remainder so that callers can round up.
// -----------------------------------------------------------------------------
module pfb_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [pfb_pkg::DIV_NUM_W-1:0] num,
	input  logic [pfb_pkg::DIV_DEN_W-1:0] den,
	output logic                          busy,
	output logic [pfb_pkg::DIV_NUM_W-1:0] quot,
	output logic                          rem_nz
);
	import pfb_pkg::*;

	logic                 busy_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_NUM_W-1:0] quot_q;
	logic [DIV_DEN_W:0]   shifted;
	logic                 fits;

	assign shifted = {rem_q, quot_q[DIV_NUM_W-1]};
	assign fits    = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_CNT_W'(DIV_NUM_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q  <= den;
			rem_q  <= '0;
			quot_q <= num;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= DIV_DEN_W'(shifted - {1'b0, den_q});
			end else begin
				rem_q <= shifted[DIV_DEN_W-1:0];
			end
			quot_q <= {quot_q[DIV_NUM_W-2:0], fits};
		end
	end

	assign busy   = busy_q;
	assign quot   = quot_q;
	assign rem_nz = |rem_q;

endmodule

>>> hw/rtl/pfb_datapath.sv
// -----------------------------------------------------------------------------
// Fan boost datapath
// Configuration registers, boost state, the activation and fade decisions,
// the products for learning and fading, the shared divider and the output
// register.
// -----------------------------------------------------------------------------
module pfb_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  pfb_pkg::pfb_cmd_t               cmd,
	output pfb_pkg::pfb_status_t            status,
	input  logic                            cfg_we,
	input  logic [pfb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pfb_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic [pfb_pkg::IN_TDATA_W-1:0]  in_data,
	input  logic                            in_fault,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [pfb_pkg::OUT_TDATA_W-1:0] out_data,
	output logic                            out_boost
);
	import pfb_pkg::*;

	// Configuration.
	logic [THR_W-1:0]  thr_q;
	logic [MS_W-1:0]   fade_ms_q;
	logic [MS_W-1:0]   learn_ms_q;
	logic [BAND_W-1:0] band_q;
	logic [PCT_W-1:0]  pct_min_q;
	logic [PCT_W-1:0]  pct_max_q;
	logic              lock_q;
	logic [MS_W-1:0]   l_eff;

	// Captured item.
	logic [TIME_W-1:0]         time_q;
	logic signed [POWER_W-1:0] power_q;
	logic [TEMP_W-1:0]         temp_q;
	logic                      fault_q;

	// Boost state.
	logic              above_valid_q;
	logic              fade_valid_q;
	logic              active_q;
	logic              learned_done_q;
	logic [PCT_W-1:0]  boost_pct_q;
	logic [TIME_W-1:0] above_since_q;
	logic [TIME_W-1:0] fade_start_q;
	logic [TIME_W-1:0] boost_start_q;
	logic [TEMP_W-1:0] start_temp_q;
	logic [PCT_W-1:0]  pct_at_fade_q;

	// Decision.
	logic              neg_c;
	logic              above_c;
	logic [TIME_W-1:0] since_c;
	logic [TIME_W-1:0] bstart_c;
	logic [TIME_W-1:0] fstart_c;
	logic [TIME_W-1:0] e_c;
	logic              activate_c;
	logic              act_c;
	logic              ld_c;
	logic              learn_go_c;
	logic              fade_end_c;
	logic [TEMP_W-1:0] st_temp_c;
	logic [PCT_W-1:0]  paf_c;
	logic [TEMP_W:0]   dt_c;
	logic [TEMP_W:0]   dt_abs_c;
	kind_t             kind_c;

	kind_t            kind_q;
	logic [MAG_W-1:0] mag_q;
	logic             dt_neg_q;
	logic [MS_W-1:0]  diff_q;

	logic [RATE_PROD_W-1:0] rate_prod_q;
	logic [BAND_PROD_W-1:0] band_prod_q;
	logic [DIV_NUM_W-1:0]   step_prod_q;
	logic [FADE_PROD_W-1:0] fade_prod_q;
	logic                   exceed_q;

	logic [DIV_NUM_W-1:0] div_num;
	logic [DIV_DEN_W-1:0] div_den;
	logic                 div_busy;
	logic [DIV_NUM_W-1:0] quot;
	logic                 rem_nz;

	logic [QW-1:0]    q_ceil;
	logic [QW-1:0]    rise_sum;
	logic [PCT_W-1:0] fall_pct;
	logic [PCT_W-1:0] fall_new;
	logic [PCT_W-1:0] rise_new;
	logic [PCT_W-1:0] np;
	logic [PCT_W-1:0] boost_next;
	logic [PCT_W-1:0] extra_c;

	logic             m_valid_q;
	logic [PCT_W-1:0] m_extra_q;
	logic [PCT_W-1:0] m_learned_q;
	logic             m_boost_q;
	logic             out_free;

	assign l_eff = (learn_ms_q == '0) ? MS_W'(1) : learn_ms_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q      <= THR_RST;
			fade_ms_q  <= FADE_RST;
			learn_ms_q <= LEARN_RST;
			band_q     <= BAND_RST;
			pct_min_q  <= PCT_MIN_RST;
			pct_max_q  <= PCT_MAX_RST;
			lock_q     <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_THRESHOLD_POWER: thr_q      <= cfg_data[THR_W-1:0];
				CFG_FADE_MS:         fade_ms_q  <= cfg_data[MS_W-1:0];
				CFG_LEARN_MS:        learn_ms_q <= cfg_data[MS_W-1:0];
				CFG_RATE_DEADBAND:   band_q     <= cfg_data[BAND_W-1:0];
				CFG_PCT_MIN:         pct_min_q  <= cfg_data[PCT_W-1:0];
				CFG_PCT_MAX:         pct_max_q  <= cfg_data[PCT_W-1:0];
				CFG_LEARNING_LOCKED: lock_q     <= cfg_data[0];
				default: begin
					// The start percentage only acts through reset, which loads
					// its reset value, so a write to it changes nothing.
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			time_q  <= in_data[TIME_W-1:0];
			power_q <= in_data[POWER_LSB +: POWER_W];
			temp_q  <= in_data[TEMP_LSB +: TEMP_W];
			fault_q <= in_fault;
		end
	end

	always_comb begin
		neg_c      = power_q[POWER_W-1] || (power_q == '0) || fault_q;
		above_c    = $unsigned(power_q) >= thr_q;
		since_c    = above_valid_q ? above_since_q : time_q;
		activate_c = !active_q && ((time_q - since_c) >= ACTIVATE_MS);
		act_c      = active_q || activate_c;
		bstart_c   = activate_c ? time_q : boost_start_q;
		ld_c       = activate_c ? 1'b0 : learned_done_q;
		learn_go_c = !ld_c && ((time_q - bstart_c) >= TIME_W'(l_eff));
		st_temp_c  = activate_c ? temp_q : start_temp_q;
		fstart_c   = fade_valid_q ? fade_start_q : time_q;
		paf_c      = fade_valid_q ? pct_at_fade_q : boost_pct_q;
		e_c        = time_q - fstart_c;
		fade_end_c = e_c >= TIME_W'(fade_ms_q);
		dt_c       = {temp_q[TEMP_W-1], temp_q} - {st_temp_c[TEMP_W-1], st_temp_c};
		dt_abs_c   = dt_c[TEMP_W] ? -dt_c : dt_c;
		if (neg_c) begin
			kind_c = KIND_ZERO;
		end else if (above_c) begin
			if (!act_c) begin
				kind_c = KIND_ZERO;
			end else if (learn_go_c) begin
				kind_c = KIND_LEARN;
			end else begin
				kind_c = KIND_BOOST;
			end
		end else if (active_q && !fade_end_c) begin
			kind_c = KIND_FADE;
		end else begin
			kind_c = KIND_ZERO;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			above_valid_q  <= 1'b0;
			fade_valid_q   <= 1'b0;
			active_q       <= 1'b0;
			learned_done_q <= 1'b0;
			boost_pct_q    <= START_PCT;
			kind_q         <= KIND_ZERO;
		end else begin
			if (cmd.decide) begin
				kind_q <= kind_c;
				if (neg_c) begin
					active_q      <= 1'b0;
					above_valid_q <= 1'b0;
					fade_valid_q  <= 1'b0;
				end else if (above_c) begin
					fade_valid_q   <= 1'b0;
					above_valid_q  <= 1'b1;
					active_q       <= act_c;
					learned_done_q <= ld_c || learn_go_c;
				end else begin
					above_valid_q <= 1'b0;
					if (active_q) begin
						active_q     <= !fade_end_c;
						fade_valid_q <= !fade_end_c;
					end
				end
			end
			if (cmd.commit) begin
				boost_pct_q <= boost_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			mag_q    <= dt_abs_c[MAG_W-1:0];
			dt_neg_q <= dt_c[TEMP_W];
			diff_q   <= fade_ms_q - e_c[MS_W-1:0];
			if (!neg_c && above_c) begin
				above_since_q <= since_c;
				if (activate_c) begin
					boost_start_q <= time_q;
					start_temp_q  <= temp_q;
				end
			end
			if (!neg_c && !above_c && active_q) begin
				fade_start_q  <= fstart_c;
				pct_at_fade_q <= paf_c;
			end
		end
		if (cmd.mult) begin
			rate_prod_q <= RATE_PROD_W'(mag_q) * RATE_PROD_W'(RATE_K);
			band_prod_q <= BAND_PROD_W'(band_q) * BAND_PROD_W'(l_eff);
			step_prod_q <= DIV_NUM_W'(mag_q) * DIV_NUM_W'(STEP_K);
			fade_prod_q <= FADE_PROD_W'(pct_at_fade_q) * FADE_PROD_W'(diff_q);
		end
		if (cmd.div_start) begin
			exceed_q <= BAND_PROD_W'(rate_prod_q) > band_prod_q;
		end
	end

	always_comb begin
		if (kind_q == KIND_LEARN) begin
			div_num = step_prod_q;
			div_den = DIV_DEN_W'({l_eff, STEP_SHIFT'(0)});
		end else begin
			div_num = DIV_NUM_W'({fade_prod_q, 1'b0}) + DIV_NUM_W'(fade_ms_q);
			div_den = DIV_DEN_W'({fade_ms_q, 1'b0});
		end
	end

	pfb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.quot   (quot),
		.rem_nz (rem_nz)
	);

	always_comb begin
		q_ceil   = QW'(quot) + QW'(rem_nz);
		rise_sum = QW'(quot) + QW'(boost_pct_q);
		fall_pct = boost_pct_q - q_ceil[PCT_W-1:0];
		if ((q_ceil > QW'(boost_pct_q)) || (fall_pct < pct_min_q)) begin
			fall_new = pct_min_q;
		end else begin
			fall_new = fall_pct;
		end
		if (rise_sum > QW'(pct_max_q)) begin
			rise_new = pct_max_q;
		end else begin
			rise_new = rise_sum[PCT_W-1:0];
		end
		if (!exceed_q) begin
			np = boost_pct_q;
		end else if (dt_neg_q) begin
			np = fall_new;
		end else begin
			np = rise_new;
		end
		boost_next = ((kind_q == KIND_LEARN) && !lock_q) ? np : boost_pct_q;
		case (kind_q)
			KIND_BOOST: extra_c = boost_next;
			KIND_LEARN: extra_c = boost_next;
			KIND_FADE:  extra_c = quot[PCT_W-1:0];
			default:    extra_c = '0;
		endcase
	end

	assign out_free = !m_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			m_valid_q <= 1'b1;
		end else if (out_ready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			m_extra_q   <= extra_c;
			m_learned_q <= boost_next;
			m_boost_q   <= active_q;
		end
	end

	assign status.kind     = kind_q;
	assign status.div_busy = div_busy;
	assign status.out_free = out_free;

	assign out_valid = m_valid_q;
	assign out_data  = {OUT_PAD_W'(0), m_learned_q, m_extra_q};
	assign out_boost = m_boost_q;

endmodule

>>> hw/rtl/pfb_ctrl.sv
// -----------------------------------------------------------------------------
// Fan boost controller
// Sequences one evaluation through decision, multiplication, division (only
// when it learns or fades) and result write-back.
// -----------------------------------------------------------------------------
module pfb_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  pfb_pkg::pfb_status_t status,
	output pfb_pkg::pfb_cmd_t    cmd
);
	import pfb_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   needs_div;

	assign needs_div = (status.kind == KIND_LEARN) || (status.kind == KIND_FADE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: state_d = ST_MULT;
			ST_MULT: begin
				state_d = needs_div ? ST_START : ST_COMMIT;
			end
			ST_START: state_d = ST_DIV;
			ST_DIV: begin
				if (!status.div_busy) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready      = 1'b0;
		cmd.capture   = 1'b0;
		cmd.decide    = 1'b0;
		cmd.mult      = 1'b0;
		cmd.div_start = 1'b0;
		cmd.commit    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_DECIDE: cmd.decide    = 1'b1;
			ST_MULT:   cmd.mult      = 1'b1;
			ST_START:  cmd.div_start = 1'b1;
			ST_COMMIT: cmd.commit    = status.out_free;
			default: begin
			end
		endcase
	end

endmodule

>>> hw/rtl/power_feedforward_fan_boost_unit.sv
// -----------------------------------------------------------------------------
// Power feed-forward fan boost unit
// Turns load power and temperature readings into an extra fan drive
// percentage, learning the boost level from the temperature rate.
// -----------------------------------------------------------------------------
// One evaluation is handled at a time. One that learns or fades also runs
// the shared divider, which produces one quotient bit per cycle over 29
// bits, before write-back. A finished result waits in the output
// register, so the next evaluation is taken while it is still pending, and the
// block only stalls in write-back when that register is still full.
`include "power_feedforward_fan_boost_unit_macros.svh"

module power_feedforward_fan_boost_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pfb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pfb_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// time_ms [31:0], power [47:32], temperature [59:48], zero [63:60]
	input  logic [pfb_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// sensor_fault
	input  logic                            s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// extra_pct [6:0], learned_pct [13:7], zero [15:14]
	output logic [pfb_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	// boost_on
	output logic                            m_axis_tuser
);
	import pfb_pkg::*;

	pfb_cmd_t    cmd;
	pfb_status_t status;

	pfb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	pfb_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (s_axis_tdata),
		.in_fault  (s_axis_tuser),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_boost (m_axis_tuser)
	);

	`PFB_ASSERT_NEXT(a_busy_after_transfer, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken again while an evaluation is in progress")
	`PFB_ASSERT_NOW(a_div_idle_when_ready, s_axis_tready, !status.div_busy, "divider still running while the block is ready")
	`PFB_ASSERT_NOW(a_off_gives_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[6:0] == 7'd0, "extra drive given while the boost is off")

endmodule
